>>> rtl/scc_pkg.sv
// Shared types, constants and the arctangent table for the coordinate converter.
`default_nettype none
package scc_pkg;

  localparam int COORD_W = 32;
  localparam int GUARD   = 8;
  localparam int DW      = 44;  // datapath coordinate width
  localparam int AW      = 34;  // datapath angle width
  localparam int TAB_LEN = 40;

  localparam logic [31:0] INV_GAIN = 32'd2608131496;
  localparam logic signed [AW-1:0] QUARTER = AW'(64'sd1073741824);
  localparam logic signed [AW-1:0] HALF    = AW'(64'sd2147483648);

  typedef enum logic [1:0] {
    K_SPH_XYZ    = 2'd0,
    K_XYZ_SPH    = 2'd1,
    K_XYZ_AZIALT = 2'd2,
    K_AZIALT_XYZ = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t                  kind;
    logic                   bad;
    logic                   zero_xy;
    logic                   zero_rz;
    logic signed [DW-1:0]   x;
    logic signed [DW-1:0]   y;
    logic signed [DW-1:0]   aux;
    logic signed [AW-1:0]   z;
    logic signed [AW-1:0]   ang2;
  } item_t;

  // rotation mode for spherical inputs, vectoring for Cartesian inputs
  function automatic logic is_rot(input kind_t k);
    return (k == K_SPH_XYZ) || (k == K_AZIALT_XYZ);
  endfunction

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [AW-1:0] atan_tab(input int i);
    logic [31:0] t;
    case (i)
      0: t = 32'd536870912;   1: t = 32'd316933406;   2: t = 32'd167458907;
      3: t = 32'd85004756;    4: t = 32'd42667331;    5: t = 32'd21354465;
      6: t = 32'd10679838;    7: t = 32'd5340245;     8: t = 32'd2670163;
      9: t = 32'd1335087;     10: t = 32'd667544;     11: t = 32'd333772;
      12: t = 32'd166886;     13: t = 32'd83443;      14: t = 32'd41722;
      15: t = 32'd20861;      16: t = 32'd10430;      17: t = 32'd5215;
      18: t = 32'd2608;       19: t = 32'd1304;       20: t = 32'd652;
      21: t = 32'd326;        22: t = 32'd163;        23: t = 32'd81;
      24: t = 32'd41;         25: t = 32'd20;         26: t = 32'd10;
      27: t = 32'd5;          28: t = 32'd3;          29: t = 32'd1;
      30: t = 32'd1;
      default: t = 32'd0;
    endcase
    return {{(AW-32){1'b0}}, t};
  endfunction

endpackage
`default_nettype wire

>>> rtl/scc_gain.sv
// Two-stage CORDIC gain compensation on x, magnitude rounded half up.
`default_nettype none
module scc_gain import scc_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  input  wire logic  apply,
  input  wire item_t in_item,
  output logic       out_valid,
  output item_t      out_item
);

  logic            valid_a_r, apply_a_r, neg_a_r;
  item_t           item_a_r;
  logic [63:0]     lo_a_r;
  logic [DW-1:0]   hi_a_r;
  logic            valid_b_r;
  item_t           item_b_r;

  logic [DW-1:0]   mag;
  logic [DW-1:0]   r_sum;
  item_t           item_b_nxt;

  always_comb begin
    mag = in_item.x[DW-1] ? DW'(-in_item.x) : DW'(in_item.x);
  end

  always_comb begin
    r_sum = hi_a_r + DW'(lo_a_r[63:32]) + DW'(lo_a_r[31]);
    item_b_nxt = item_a_r;
    if (apply_a_r) begin
      item_b_nxt.x = neg_a_r ? -$signed(r_sum) : $signed(r_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_a_r <= 1'b0;
      valid_b_r <= 1'b0;
    end else begin
      valid_a_r <= in_valid;
      valid_b_r <= valid_a_r;
    end
    apply_a_r <= apply;
    neg_a_r   <= in_item.x[DW-1];
    item_a_r  <= in_item;
    lo_a_r    <= 64'(mag[31:0]) * 64'(INV_GAIN);
    hi_a_r    <= DW'(mag[DW-1:32]) * DW'(INV_GAIN);
    item_b_r  <= item_b_nxt;
  end

  assign out_valid = valid_b_r;
  assign out_item  = item_b_r;

endmodule
`default_nettype wire

>>> rtl/scc_cell.sv
// One CORDIC micro-rotation cell, rotation or vectoring chosen per item.
`default_nettype none
module scc_cell import scc_pkg::*; #(
  parameter int IDX = 0
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  input  wire item_t in_item,
  output logic       out_valid,
  output item_t      out_item
);

  localparam logic signed [AW-1:0] STEP = atan_tab(IDX);

  logic                  valid_r;
  item_t                 item_r;
  item_t                 item_nxt;
  logic signed [DW-1:0]  x, y, xs, ys;
  logic signed [AW-1:0]  z;
  logic                  ccw;

  always_comb begin
    x  = in_item.x;
    y  = in_item.y;
    z  = in_item.z;
    xs = x >>> IDX;
    ys = y >>> IDX;
    ccw = is_rot(in_item.kind) ? !z[AW-1] : y[DW-1];
    item_nxt = in_item;
    if (ccw) begin
      item_nxt.x = x - ys;
      item_nxt.y = y + xs;
      item_nxt.z = z - STEP;
    end else begin
      item_nxt.x = x + ys;
      item_nxt.y = y - xs;
      item_nxt.z = z + STEP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
    item_r <= item_nxt;
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule
`default_nettype wire

>>> rtl/scc_chain.sv
// Quadrant pre-rotation stage followed by a row of CORDIC cells.
`default_nettype none
module scc_chain import scc_pkg::*; #(
  parameter int STAGES = 30
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  input  wire item_t in_item,
  output logic       out_valid,
  output item_t      out_item
);

  logic   valid_r;
  item_t  item_r;
  item_t  item_nxt;
  logic   [STAGES:0] v;
  item_t  it [STAGES+1];

  // bring the vector into the right half plane / the angle into +-quarter turn
  always_comb begin
    item_nxt = in_item;
    if (is_rot(in_item.kind)) begin
      if (in_item.z > QUARTER) begin
        item_nxt.z = in_item.z - HALF;
        item_nxt.x = -in_item.x;
        item_nxt.y = -in_item.y;
      end else if (in_item.z < -QUARTER) begin
        item_nxt.z = in_item.z + HALF;
        item_nxt.x = -in_item.x;
        item_nxt.y = -in_item.y;
      end
    end else if (in_item.x[DW-1]) begin
      item_nxt.x = -in_item.x;
      item_nxt.y = -in_item.y;
      item_nxt.z = HALF;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
    item_r <= item_nxt;
  end

  assign v[0]  = valid_r;
  assign it[0] = item_r;

  for (genvar i = 0; i < STAGES; i++) begin : g_cell
    scc_cell #(.IDX(i)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_valid (v[i]),
      .in_item  (it[i]),
      .out_valid(v[i+1]),
      .out_item (it[i+1])
    );
  end

  assign out_valid = v[STAGES];
  assign out_item  = it[STAGES];

endmodule
`default_nettype wire

>>> rtl/spherical_cartesian_converter_top.sv
// Top level: spherical <-> Cartesian conversion through two CORDIC passes.
//
//  channel  ports                         transfer
//  input    start, busy, in_*             start && !busy at a rising edge
//  result   out_valid, out_*              out_valid for one cycle
//
// Fully pipelined: one item per cycle, busy is always low.
// Register order: input register, gain, pass 1 (pre-rotation plus CORDIC_STAGES
// cells), gain, pass 2 (pre-rotation plus CORDIC_STAGES cells), gain, output register.
// Reset clears only the valid bits of the stages.
// The receiver cannot stall; each result is shown for exactly one cycle.
`default_nettype none
module spherical_cartesian_converter_top import scc_pkg::*; #(
  parameter int CORDIC_STAGES = 30
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         in_kind,
  input  wire logic [31:0]        in_angle_lon,
  input  wire logic signed [31:0] in_angle_lat,
  input  wire logic signed [31:0] in_radius,
  input  wire logic signed [31:0] in_coord_x,
  input  wire logic signed [31:0] in_coord_y,
  input  wire logic signed [31:0] in_coord_z,
  output logic                    out_valid,
  output logic signed [31:0]      out_x,
  output logic signed [31:0]      out_y,
  output logic signed [31:0]      out_z,
  output logic [31:0]             out_lon,
  output logic signed [31:0]      out_lat,
  output logic [30:0]             out_radius,
  output logic                    out_bad_radius,
  output logic                    out_saturated
);

  localparam logic signed [DW:0] C_MAX = {{(DW+1-32){1'b0}}, 32'h7FFF_FFFF};
  localparam logic signed [DW:0] C_MIN = {{(DW+1-32){1'b1}}, 32'h8000_0000};

  logic   v0_r;
  item_t  item0_r, item0_nxt;
  logic   v1, v2, v3, v4, v5;
  item_t  it1, it2, it3, it3z, it4, it5;
  item_t  mid;

  logic                       valid_r;
  logic signed [31:0]         x_r, y_r, z_r, lat_r;
  logic [31:0]                lon_r;
  logic [30:0]                rad_r;
  logic                       bad_r, sat_r;
  logic signed [31:0]         x_nxt, y_nxt, z_nxt, lat_nxt;
  logic [31:0]                lon_nxt;
  logic [30:0]                rad_nxt;
  logic                       sat_nxt;

  function automatic logic signed [DW-1:0] widen(input logic signed [31:0] v);
    return {{(DW-32-GUARD){v[31]}}, v, {GUARD{1'b0}}};
  endfunction

  function automatic logic signed [DW:0] rnd(input logic signed [DW-1:0] v);
    logic signed [DW:0] t;
    t = {v[DW-1], v} + (DW+1)'(1 << (GUARD-1));
    return t >>> GUARD;
  endfunction

  // {clip flag, value}
  function automatic logic [32:0] sat32(input logic signed [DW:0] t);
    logic [32:0] r;
    if (t > C_MAX) r = {1'b1, 32'h7FFF_FFFF};
    else if (t < C_MIN) r = {1'b1, 32'h8000_0000};
    else r = {1'b0, t[31:0]};
    return r;
  endfunction

  assign busy = 1'b0;

  always_comb begin
    item0_nxt = '0;
    item0_nxt.kind = kind_t'(in_kind);
    if (is_rot(kind_t'(in_kind))) begin
      item0_nxt.x    = widen(in_radius);
      item0_nxt.z    = AW'(in_angle_lat);
      item0_nxt.ang2 = AW'($signed(in_angle_lon));
      item0_nxt.bad  = (kind_t'(in_kind) == K_AZIALT_XYZ) && in_radius[31];
    end else begin
      item0_nxt.x   = widen(in_coord_x);
      item0_nxt.y   = widen(in_coord_y);
      item0_nxt.aux = widen(in_coord_z);
      if (kind_t'(in_kind) == K_XYZ_AZIALT) begin
        item0_nxt.y   = -widen(in_coord_y);
        item0_nxt.aux = -widen(in_coord_z);
      end
      item0_nxt.zero_xy = (in_coord_x == 32'sd0) && (in_coord_y == 32'sd0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= start && !busy;
    end
    item0_r <= item0_nxt;
  end

  scc_gain u_gain1 (
    .clk(clk), .rst_n(rst_n), .in_valid(v0_r), .apply(is_rot(item0_r.kind)),
    .in_item(item0_r), .out_valid(v1), .out_item(it1)
  );

  scc_chain #(.STAGES(CORDIC_STAGES)) u_pass1 (
    .clk(clk), .rst_n(rst_n), .in_valid(v1), .in_item(it1),
    .out_valid(v2), .out_item(it2)
  );

  // set up the second pass
  always_comb begin
    mid = it2;
    if (is_rot(it2.kind)) begin
      mid.y   = '0;
      mid.z   = it2.ang2;
      mid.aux = it2.y;
    end else begin
      mid.y    = it2.aux;
      mid.z    = '0;
      mid.ang2 = it2.zero_xy ? '0 : it2.z;
    end
  end

  scc_gain u_gain2 (
    .clk(clk), .rst_n(rst_n), .in_valid(v2), .apply(1'b1),
    .in_item(mid), .out_valid(v3), .out_item(it3)
  );

  always_comb begin
    it3z = it3;
    it3z.zero_rz = (it3.x == '0) && (it3.y == '0);
  end

  scc_chain #(.STAGES(CORDIC_STAGES)) u_pass2 (
    .clk(clk), .rst_n(rst_n), .in_valid(v3), .in_item(it3z),
    .out_valid(v4), .out_item(it4)
  );

  scc_gain u_gain3 (
    .clk(clk), .rst_n(rst_n), .in_valid(v4), .apply(!is_rot(it4.kind)),
    .in_item(it4), .out_valid(v5), .out_item(it5)
  );

  always_comb begin
    logic signed [DW-1:0] d, b;
    logic signed [AW-1:0] zl;
    logic signed [DW:0]   t;
    logic [32:0]          sx, sy, sz;
    x_nxt = '0; y_nxt = '0; z_nxt = '0;
    lon_nxt = '0; lat_nxt = '0; rad_nxt = '0; sat_nxt = 1'b0;
    d  = it5.y;
    b  = it5.aux;
    zl = it5.zero_rz ? '0 : it5.z;
    t  = rnd(it5.x);
    if (it5.kind == K_AZIALT_XYZ) begin
      d = -it5.y;
      b = -it5.aux;
    end
    sx = sat32(rnd(it5.x));
    sy = sat32(rnd(d));
    sz = sat32(rnd(b));
    if (is_rot(it5.kind)) begin
      if (!it5.bad) begin
        x_nxt   = sx[31:0];
        y_nxt   = sy[31:0];
        z_nxt   = sz[31:0];
        sat_nxt = sx[32] | sy[32] | sz[32];
      end
    end else begin
      if (zl > QUARTER) zl = QUARTER;
      if (zl < -QUARTER) zl = -QUARTER;
      lon_nxt = it5.ang2[31:0];
      lat_nxt = zl[31:0];
      if (t > C_MAX) begin
        rad_nxt = 31'h7FFF_FFFF;
        sat_nxt = 1'b1;
      end else if (t[DW]) begin
        rad_nxt = '0;
      end else begin
        rad_nxt = t[30:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= v5;
    end
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    z_r   <= z_nxt;
    lon_r <= lon_nxt;
    lat_r <= lat_nxt;
    rad_r <= rad_nxt;
    bad_r <= it5.bad;
    sat_r <= sat_nxt;
  end

  assign out_valid      = valid_r;
  assign out_x          = x_r;
  assign out_y          = y_r;
  assign out_z          = z_r;
  assign out_lon        = lon_r;
  assign out_lat        = lat_r;
  assign out_radius     = rad_r;
  assign out_bad_radius = bad_r;
  assign out_saturated  = sat_r;

endmodule
`default_nettype wire
